// ===== rtl/core/smp_pkg.sv =====
// Shared types and constants for the stable matching block.
package smp_pkg;

  localparam int unsigned IDX_W        = 4;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned PERSON_LIMIT = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD_PROP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_ACC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN       = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DEQ  = 6'b000010,
    ST_TRY  = 6'b000100,
    ST_LOOK = 6'b001000,
    ST_CMP  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

endpackage

// ===== rtl/core/stable_matching_proposals.sv =====
// Stable matching by proposals: preference tables, proposal sequencer, pair output.
// Loads are taken one beat per cycle while idle.
// A run dequeues a proposer, checks its list is not exhausted and looks up its next choice;
// a contested acceptor adds a rank compare (up to n*n proposals, one shared comparator).
// On an empty queue it sends n beats, one per cycle while the output does not stall.
// Asynchronous active-low reset clears control and partner flags, sets person count to 16.
module stable_matching_proposals #(
  parameter int unsigned MAX_PERSONS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [smp_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [smp_pkg::CMD_W-1:0]   command_i,
  input  logic [smp_pkg::IDX_W-1:0]   person_i,
  input  logic [smp_pkg::IDX_W-1:0]   position_i,
  input  logic [smp_pkg::IDX_W-1:0]   choice_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [smp_pkg::IDX_W-1:0]   proposer_o,
  output logic [smp_pkg::IDX_W-1:0]   partner_o,
  output logic                        matched_o,
  output logic                        last_o
);
  import smp_pkg::*;

  localparam int unsigned NMAX  = (MAX_PERSONS < PERSON_LIMIT) ? MAX_PERSONS : PERSON_LIMIT;
  localparam int unsigned LW    = $clog2(NMAX);
  localparam int unsigned PW    = $clog2(MAX_PERSONS);
  localparam int unsigned AW    = 2 * PW;
  localparam int unsigned DEPTH = 1 << AW;

  state_e             state_q;
  logic [CNT_W-1:0]   pcount_q;
  logic [LW:0]        n_q;
  logic [LW:0]        count_q;
  logic [LW-1:0]      head_q;
  logic [LW-1:0]      p_q;
  logic [LW-1:0]      a_q;
  logic [LW-1:0]      idx_q;
  logic [NMAX-1:0]    pp_valid_q;
  logic [NMAX-1:0]    ap_valid_q;
  logic [LW-1:0]      pp_acc_q  [NMAX];
  logic [LW-1:0]      ap_prop_q [NMAX];
  logic [LW:0]        np_q      [NMAX];
  logic [LW-1:0]      queue_q   [NMAX];

  logic [IDX_W-1:0]   pl_mem [DEPTH];
  logic [IDX_W-1:0]   ar_mem [DEPTH];
  logic [IDX_W-1:0]   pl_rd_q;
  logic [IDX_W-1:0]   ar_new_q;
  logic [IDX_W-1:0]   ar_held_q;

  logic               out_valid_q;
  logic [IDX_W-1:0]   proposer_q;
  logic [IDX_W-1:0]   partner_q;
  logic               matched_q;
  logic               last_q;

  logic               in_acc;
  logic               ld_prop;
  logic               ld_acc;
  logic               run_go;
  logic [CNT_W-1:0]   pc_eff;
  logic [LW:0]        run_n;
  logic [CNT_W-1:0]   cmp_a;
  logic [CNT_W-1:0]   cmp_b;
  logic               cmp_lt;
  logic [LW-1:0]      acc_a;
  logic               look_free;
  logic               bump;
  logic [LW-1:0]      held;
  logic [LW+1:0]      tail_sum;
  logic [LW-1:0]      tail;
  logic [LW-1:0]      head_nx;
  logic               out_free;
  logic               emit_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign ld_prop    = in_acc && (command_i == CMD_LOAD_PROP)
                      && (32'(person_i) < MAX_PERSONS) && (32'(position_i) < MAX_PERSONS);
  assign ld_acc     = in_acc && (command_i == CMD_LOAD_ACC)
                      && (32'(person_i) < MAX_PERSONS) && (32'(position_i) < MAX_PERSONS)
                      && (32'(choice_i) < MAX_PERSONS);
  assign run_go     = in_acc && (command_i == CMD_RUN);

  always_comb begin
    pc_eff = pcount_q;
    if (pcount_q == '0) begin
      pc_eff = CNT_W'(1);
    end else if (32'(pcount_q) > NMAX) begin
      pc_eff = CNT_W'(NMAX);
    end
  end
  assign run_n = (LW+1)'(pc_eff);

  // shared comparator
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    unique case (state_q)
      ST_TRY: begin
        cmp_a = CNT_W'(np_q[p_q]);
        cmp_b = CNT_W'(n_q);
      end
      ST_LOOK: begin
        cmp_a = CNT_W'(pl_rd_q);
        cmp_b = CNT_W'(n_q);
      end
      ST_CMP: begin
        cmp_a = CNT_W'(ar_new_q);
        cmp_b = CNT_W'(ar_held_q);
      end
      default: ;
    endcase
  end
  assign cmp_lt = (cmp_a < cmp_b);

  assign acc_a     = LW'(pl_rd_q);
  assign look_free = !ap_valid_q[acc_a];
  assign bump      = (state_q == ST_CMP) && cmp_lt;
  assign held      = ap_prop_q[a_q];
  assign tail_sum  = (LW+2)'(head_q) + (LW+2)'(count_q);
  assign tail      = (32'(tail_sum) >= NMAX) ? LW'(tail_sum - (LW+2)'(NMAX)) : LW'(tail_sum);
  assign head_nx   = (32'(head_q) == NMAX - 1) ? '0 : head_q + LW'(1);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit_last = ((LW+1)'(idx_q) + (LW+1)'(1)) == n_q;

  // preference tables
  always_ff @(posedge clk_i) begin
    if (ld_prop) begin
      pl_mem[{PW'(person_i), PW'(position_i)}] <= choice_i;
    end
    pl_rd_q <= pl_mem[{PW'(p_q), PW'(np_q[p_q])}];
  end

  always_ff @(posedge clk_i) begin
    if (ld_acc) begin
      ar_mem[{PW'(person_i), PW'(choice_i)}] <= position_i;
    end
    ar_new_q  <= ar_mem[{PW'(acc_a), PW'(p_q)}];
    ar_held_q <= ar_mem[{PW'(acc_a), PW'(ap_prop_q[acc_a])}];
  end

  // matching payload arrays
  always_ff @(posedge clk_i) begin
    if (run_go) begin
      for (int i = 0; i < NMAX; i++) begin
        queue_q[i] <= LW'(i);
        np_q[i]    <= '0;
      end
    end
    if ((state_q == ST_TRY) && cmp_lt) begin
      np_q[p_q] <= np_q[p_q] + (LW+1)'(1);
    end
    if ((state_q == ST_LOOK) && cmp_lt && look_free) begin
      pp_acc_q[p_q]    <= acc_a;
      ap_prop_q[acc_a] <= p_q;
    end
    if (bump) begin
      pp_acc_q[p_q]  <= a_q;
      ap_prop_q[a_q] <= p_q;
      queue_q[tail]  <= held;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pcount_q    <= COUNT_RESET;
      n_q         <= '0;
      count_q     <= '0;
      head_q      <= '0;
      p_q         <= '0;
      a_q         <= '0;
      idx_q       <= '0;
      pp_valid_q  <= '0;
      ap_valid_q  <= '0;
      out_valid_q <= 1'b0;
      proposer_q  <= '0;
      partner_q   <= '0;
      matched_q   <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pcount_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (run_go) begin
            n_q        <= run_n;
            count_q    <= run_n;
            head_q     <= '0;
            pp_valid_q <= '0;
            ap_valid_q <= '0;
            state_q    <= ST_DEQ;
          end
        end
        ST_DEQ: begin
          if (count_q == '0) begin
            idx_q   <= '0;
            state_q <= ST_EMIT;
          end else begin
            p_q     <= queue_q[head_q];
            head_q  <= head_nx;
            count_q <= count_q - (LW+1)'(1);
            state_q <= ST_TRY;
          end
        end
        ST_TRY: begin
          state_q <= cmp_lt ? ST_LOOK : ST_DEQ;
        end
        ST_LOOK: begin
          if (!cmp_lt) begin
            state_q <= ST_TRY;
          end else if (look_free) begin
            pp_valid_q[p_q]   <= 1'b1;
            ap_valid_q[acc_a] <= 1'b1;
            state_q           <= ST_DEQ;
          end else begin
            a_q     <= acc_a;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (cmp_lt) begin
            pp_valid_q[p_q]  <= 1'b1;
            pp_valid_q[held] <= 1'b0;
            count_q          <= count_q + (LW+1)'(1);
            state_q          <= ST_DEQ;
          end else begin
            state_q <= ST_TRY;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            proposer_q  <= IDX_W'(idx_q);
            partner_q   <= pp_valid_q[idx_q] ? IDX_W'(pp_acc_q[idx_q]) : '0;
            matched_q   <= pp_valid_q[idx_q];
            last_q      <= emit_last;
            if (emit_last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + LW'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign proposer_o  = proposer_q;
  assign partner_o   = partner_q;
  assign matched_o   = matched_q;
  assign last_o      = last_q;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the stable matching block: table loads, runs and pair checks.
`timescale 1ns / 100ps

module testbench;
  import smp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 50;
  localparam int LONG_HOLD     = 400;
  localparam int PRINT_CAP     = 40;
  localparam int TABLE_W       = 8;
  localparam int RANDOM_BEATS  = 50;

  typedef struct packed {
    logic [IDX_W-1:0] proposer;
    logic [IDX_W-1:0] partner;
    logic             matched;
    logic             last;
  } pair_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CMD_W-1:0] command_i;
  logic [IDX_W-1:0] person_i;
  logic [IDX_W-1:0] position_i;
  logic [IDX_W-1:0] choice_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [IDX_W-1:0] proposer_o;
  logic [IDX_W-1:0] partner_o;
  logic             matched_o;
  logic             last_o;

  // predictor state
  logic [IDX_W-1:0] pref_list [PERSON_LIMIT][PERSON_LIMIT];
  logic [IDX_W-1:0] acc_rank  [PERSON_LIMIT][PERSON_LIMIT];
  logic [CNT_W-1:0] count_reg;
  pair_t            expected_pairs [$];
  pair_t            want_pair;

  int perm_buf [PERSON_LIMIT];
  int mismatch_count;
  int pairs_checked;
  int beats_sent;
  int runs_sent;
  int cycle_count;
  bit sender_idle_on;
  bit receiver_idle_on;
  bit hold_request;

  stable_matching_proposals DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .person_i    (person_i),
    .position_i  (position_i),
    .choice_i    (choice_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .proposer_o  (proposer_o),
    .partner_o   (partner_o),
    .matched_o   (matched_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int active_persons();
    if (count_reg == 0) return 1;
    if (count_reg > PERSON_LIMIT) return PERSON_LIMIT;
    return int'(count_reg);
  endfunction

  // Proposer-optimal matching, FIFO order of free proposers
  function automatic void predict_pairs();
    int    n;
    int    p;
    int    a;
    int    held;
    int    prop_mate [PERSON_LIMIT];
    int    acc_mate  [PERSON_LIMIT];
    int    place     [PERSON_LIMIT];
    int    waiting   [$];
    pair_t pr;
    n = active_persons();
    for (int i = 0; i < PERSON_LIMIT; i++) begin
      prop_mate[i] = -1;
      acc_mate[i]  = -1;
      place[i]     = 0;
    end
    for (int i = 0; i < n; i++) waiting.push_back(i);
    while (waiting.size() > 0) begin
      p = waiting.pop_front();
      while (place[p] < n) begin
        a = int'(pref_list[p][place[p]]);
        place[p]++;
        if (a >= n) continue;
        held = acc_mate[a];
        if (held < 0) begin
          prop_mate[p] = a;
          acc_mate[a]  = p;
          break;
        end
        if (acc_rank[a][p] < acc_rank[a][held]) begin
          prop_mate[p]    = a;
          acc_mate[a]     = p;
          prop_mate[held] = -1;
          waiting.push_back(held);
          break;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      pr.proposer = 4'(i);
      pr.matched  = prop_mate[i] >= 0;
      pr.partner  = pr.matched ? 4'(prop_mate[i]) : 4'd0;
      pr.last     = (i + 1 == n);
      expected_pairs.push_back(pr);
    end
  endfunction

  function automatic void make_permutation(int width);
    int j;
    int t;
    for (int i = 0; i < width; i++) perm_buf[i] = i;
    for (int i = width - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm_buf[i];
      perm_buf[i] = perm_buf[j];
      perm_buf[j] = t;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t pair %0d: %s is %0d, predicted %0d", $realtime, pairs_checked, what, got,
               want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("unexpected pair from proposer", int'(proposer_o), -1);
      end else begin
        want_pair = expected_pairs.pop_front();
        if (proposer_o !== want_pair.proposer)
          report_mismatch("proposer", int'(proposer_o), int'(want_pair.proposer));
        if (partner_o !== want_pair.partner)
          report_mismatch("partner", int'(partner_o), int'(want_pair.partner));
        if (matched_o !== want_pair.matched)
          report_mismatch("matched", int'(matched_o), int'(want_pair.matched));
        if (last_o !== want_pair.last)
          report_mismatch("last", int'(last_o), int'(want_pair.last));
      end
      pairs_checked++;
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin : receiver_stall
    int burst;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 18);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // one input beat; valid is left high for a following beat
  task automatic send_beat(logic [CMD_W-1:0] cmd, int person, int position, int choice);
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    person_i   <= 4'(person);
    position_i <= 4'(position);
    choice_i   <= 4'(choice);
    do @(posedge clk_i); while (in_stall_o);
    case (cmd)
      CMD_LOAD_PROP: pref_list[4'(person)][4'(position)] = 4'(choice);
      CMD_LOAD_ACC:  acc_rank[4'(person)][4'(choice)] = 4'(position);
      CMD_RUN: begin
        predict_pairs();
        runs_sent++;
      end
      default: ;
    endcase
    if (cmd != CMD_NONE) beats_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_count(int value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 5'(value);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    count_reg = 5'(value);
  endtask

  task automatic load_proposer_row(int p, int width);
    make_permutation(width);
    for (int k = 0; k < width; k++) send_beat(CMD_LOAD_PROP, p, k, perm_buf[k]);
  endtask

  task automatic load_acceptor_row(int a, int width);
    make_permutation(width);
    for (int q = 0; q < width; q++) send_beat(CMD_LOAD_ACC, a, perm_buf[q], q);
  endtask

  task automatic run_match();
    send_beat(CMD_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
  endtask

  // full lists for the first TABLE_W persons; the others first pick their own index,
  // so a full-size run stays on written entries
  task automatic test_table_load();
    set_count(PERSON_LIMIT);
    for (int p = 0; p < TABLE_W; p++) load_proposer_row(p, TABLE_W);
    for (int a = 0; a < TABLE_W; a++) load_acceptor_row(a, TABLE_W);
    for (int p = TABLE_W; p < PERSON_LIMIT; p++) send_beat(CMD_LOAD_PROP, p, 0, p);
  endtask

  task automatic test_directed_cases();
    set_count(31);
    run_match();
    set_count(PERSON_LIMIT);
    send_beat(CMD_NONE, 0, 0, 0);
    run_match();
    set_count(3);
    // all three want acceptor 0; proposer 1 first tries an acceptor out of use
    for (int k = 0; k < 3; k++) send_beat(CMD_LOAD_PROP, 0, k, 0);
    send_beat(CMD_LOAD_PROP, 1, 0, 15);
    send_beat(CMD_LOAD_PROP, 1, 1, 0);
    send_beat(CMD_LOAD_PROP, 1, 2, 0);
    for (int k = 0; k < 3; k++) send_beat(CMD_LOAD_PROP, 2, k, 0);
    // equal rank for proposers 0 and 1, proposer 2 preferred
    send_beat(CMD_LOAD_ACC, 0, 2, 0);
    send_beat(CMD_LOAD_ACC, 0, 2, 1);
    send_beat(CMD_LOAD_ACC, 0, 0, 2);
    send_beat(CMD_NONE, 15, 15, 15);
    run_match();
    set_count(1);
    run_match();
    set_count(0);
    run_match();
  endtask

  task automatic test_random_phases();
    int target;
    int n;
    int kind;
    target = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      sender_idle_on   = $urandom_range(0, 3) != 0;
      receiver_idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 2) == 0)
        set_count(($urandom_range(0, 7) == 0) ? TABLE_W : $urandom_range(2, 6));
      n = active_persons();
      repeat ($urandom_range(1, 3)) begin
        kind = $urandom_range(0, 9);
        if (kind < 4)
          load_proposer_row($urandom_range(0, n - 1),
                            ($urandom_range(0, 4) == 0) ? PERSON_LIMIT : n);
        else if (kind < 7)
          load_acceptor_row($urandom_range(0, n - 1), n);
        else if (kind < 9)
          send_beat(2'($urandom_range(0, 1)), $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 15));
        else
          send_beat(CMD_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 15));
      end
      run_match();
    end
  endtask

  // output held off while loads keep coming, so the input backs up
  task automatic test_backpressure();
    set_count(8);
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    hold_request     = 1'b1;
    run_match();
    for (int p = 0; p < 4; p++) load_proposer_row(p, 8);
    run_match();
  endtask

  task automatic test_full_rate();
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    set_count(TABLE_W);
    load_acceptor_row(5, TABLE_W);
    run_match();
    run_match();
    set_count(4);
    load_proposer_row(3, 4);
    run_match();
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    command_i        = CMD_LOAD_PROP;
    person_i         = '0;
    position_i       = '0;
    choice_i         = '0;
    out_stall_i      = 1'b0;
    count_reg        = COUNT_RESET;
    mismatch_count   = 0;
    pairs_checked    = 0;
    beats_sent       = 0;
    runs_sent        = 0;
    cycle_count      = 0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    hold_request     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_directed_cases();
    test_random_phases();
    test_backpressure();
    test_full_rate();
    in_valid_i <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d load and run beats, %0d matching runs, %0d pairs checked",
             beats_sent, runs_sent, pairs_checked);
    $display("including person counts 0 to 31, ties, refusals and exhausted lists");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
